[rtl/vaf_pkg.sv]
// shared constants, types and codes for the vlan allowlist filter
`timescale 1ns / 1ps
`default_nettype none
package vaf_pkg;

  localparam int COUNTER_KEYS  = 4097;
  localparam int COUNTER_WIDTH = 64;
  localparam int KEY_W         = $clog2(COUNTER_KEYS);
  localparam int VID_W         = 12;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] TPID_CTAG      = 16'h8100;
  localparam logic [15:0] TPID_STAG      = 16'h88A8;
  localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
  localparam logic [15:0] TAGGED_HDR_LEN = 16'd18;

  localparam logic [KEY_W-1:0] PLAIN_KEY    = KEY_W'(4096);
  localparam logic [KEY_W-1:0] LAST_KEY     = KEY_W'(COUNTER_KEYS - 1);
  localparam logic [VID_W-1:0] ALLOWED_RESET = VID_W'(100);

  // work kinds handed from front to back
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_BUMP = 2'd2;

  typedef logic [COUNTER_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             bump_pass;
    logic             bump_drop;
    logic             verdict;
    logic             counted;
    logic [KEY_W-1:0] key;
  } op_t;

  typedef struct packed {
    count_t seen;
    count_t pass;
    count_t drop;
  } counters_t;

endpackage
`default_nettype wire

[rtl/vaf_front.sv]
// front end: allowed vlan register and frame classification
`timescale 1ns / 1ps
`default_nettype none
module vaf_front (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire  [vaf_pkg::VID_W-1:0]   cfg_wdata,
  input  wire                         cmd,
  input  wire  [15:0]                 frame_len,
  input  wire  [15:0]                 ethertype,
  input  wire  [15:0]                 tag_control,
  input  wire  [vaf_pkg::KEY_W-1:0]   read_key,
  output vaf_pkg::op_t                op
);
  import vaf_pkg::*;

  logic [VID_W-1:0] permit_vid;
  logic [VID_W-1:0] vid;
  logic             has_tpid;

  always_ff @(posedge clk) begin
    if (rst) begin
      permit_vid <= ALLOWED_RESET;
    end else if (cfg_we) begin
      permit_vid <= cfg_wdata;
    end
  end

  assign vid      = tag_control[VID_W-1:0];
  assign has_tpid = (ethertype == TPID_CTAG) || (ethertype == TPID_STAG);

  always_comb begin
    op = '0;
    op.kind = KIND_NONE;
    if (cmd) begin
      op.key = read_key;
      if (read_key <= PLAIN_KEY) begin
        op.kind    = KIND_READ;
        op.counted = 1'b1;
      end
    end else if (frame_len < ETH_HDR_LEN) begin
      op.kind = KIND_NONE;
    end else if (!has_tpid) begin
      op.kind      = KIND_BUMP;
      op.counted   = 1'b1;
      op.bump_pass = 1'b1;
      op.key       = PLAIN_KEY;
    end else if (frame_len < TAGGED_HDR_LEN) begin
      op.kind = KIND_NONE;
    end else begin
      op.kind    = KIND_BUMP;
      op.counted = 1'b1;
      op.key     = KEY_W'(vid);
      if (vid == permit_vid) begin
        op.bump_pass = 1'b1;
      end else begin
        op.bump_drop = 1'b1;
        op.verdict   = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/vaf_queue.sv]
// short fifo of classified work between front and back
`timescale 1ns / 1ps
`default_nettype none
module vaf_queue (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  vaf_pkg::op_t  push_op,
  input  wire           pop,
  output vaf_pkg::op_t  head,
  output logic          empty,
  output logic          full
);
  import vaf_pkg::*;

  op_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/vaf_back.sv]
// back end: counter memory, clearing pass and read-modify-write
`timescale 1ns / 1ps
`default_nettype none
module vaf_back (
  input  wire                        clk,
  input  wire                        rst,
  input  vaf_pkg::op_t               head,
  input  wire                        empty,
  output logic                       pop,
  output logic                       clearing,
  output logic                       done,
  output logic                       verdict,
  output logic                       counted,
  output logic [vaf_pkg::KEY_W-1:0]  stat_key,
  output vaf_pkg::count_t            seen_count,
  output vaf_pkg::count_t            pass_count,
  output vaf_pkg::count_t            drop_count
);
  import vaf_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;

  counters_t         mem [COUNTER_KEYS];
  counters_t         rd_data;
  counters_t         upd;
  counters_t         mem_wdata;
  logic [KEY_W-1:0]  mem_waddr;
  logic              mem_we;
  logic              rd_en;
  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [KEY_W-1:0]  clr_addr;
  op_t               cur;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !empty;
  assign rd_en    = pop && (head.kind != KIND_NONE);

  // increments wrap at the counter width
  assign upd.seen = rd_data.seen + count_t'(1);
  assign upd.pass = rd_data.pass + count_t'(cur.bump_pass);
  assign upd.drop = rd_data.drop + count_t'(cur.bump_drop);

  assign mem_we    = clearing || ((state == S_CALC) && (cur.kind == KIND_BUMP));
  assign mem_waddr = clearing ? clr_addr : cur.key;
  assign mem_wdata = clearing ? '0 : upd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[head.key];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == LAST_KEY) state_next = S_IDLE;
      S_IDLE:  if (rd_en) state_next = S_CALC;
      S_CALC:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + KEY_W'(1);
      end
      done <= (pop && (head.kind == KIND_NONE)) || (state == S_CALC);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (pop && (head.kind == KIND_NONE)) begin
      verdict    <= head.verdict;
      counted    <= head.counted;
      stat_key   <= head.key;
      seen_count <= '0;
      pass_count <= '0;
      drop_count <= '0;
    end else if (state == S_CALC) begin
      verdict  <= cur.verdict;
      counted  <= cur.counted;
      stat_key <= cur.key;
      if (cur.kind == KIND_BUMP) begin
        seen_count <= upd.seen;
        pass_count <= upd.pass;
        drop_count <= upd.drop;
      end else begin
        seen_count <= rd_data.seen;
        pass_count <= rd_data.pass;
        drop_count <= rd_data.drop;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/vlan_allowlist_filter_with_stats_unit.sv]
// top level of the vlan allowlist filter with per-vlan counters
// usage:
//   a command transfer happens at a clock edge with start high and busy low;
//   cmd 0 classifies a frame summary, cmd 1 reads the counters of read_key
//   every command gives exactly one result, shown for one cycle with done high;
//   the receiver cannot stall, so results are never held back
//   the user writes the permitted vid by cfg_we / cfg_wdata while idle, unenforced
// structure:
//   the front classifies at the transfer and pushes into a two-entry queue;
//   the back pops it, reads the 4097-entry counter memory (registered read),
//   adds and writes back for counted frames, then presents the result
// flow:
//   counter work goes through the queue entry, the registered memory read
//   and the update state before done is registered; commands that touch no
//   counter go from the queue entry to done; the back pops no new item while
//   it updates a counter item; busy is high while the queue is full
// reset:
//   rst clears control and sets the permitted vid to 100, then a clearing pass
//   zeroes the counters one key per cycle, all 4097 keys, with busy high;
//   configuration writes are taken during that pass
`timescale 1ns / 1ps
`default_nettype none
module vlan_allowlist_filter_with_stats_unit (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  output logic                       busy,
  input  wire                        cmd,
  input  wire  [15:0]                frame_len,
  input  wire  [15:0]                ethertype,
  input  wire  [15:0]                tag_control,
  input  wire  [vaf_pkg::KEY_W-1:0]  read_key,
  input  wire                        cfg_we,
  input  wire  [vaf_pkg::VID_W-1:0]  cfg_wdata,
  output logic                       done,
  output logic                       verdict,
  output logic                       counted,
  output logic [vaf_pkg::KEY_W-1:0]  stat_key,
  output vaf_pkg::count_t            seen_count,
  output vaf_pkg::count_t            pass_count,
  output vaf_pkg::count_t            drop_count
);
  import vaf_pkg::*;

  op_t  front_op;
  op_t  head;
  logic push;
  logic pop;
  logic empty;
  logic full;
  logic clearing;

  // no transfer during the clearing pass or while the queue has no room
  assign busy = clearing || full;
  assign push = start && !busy;

  vaf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .frame_len   (frame_len),
    .ethertype   (ethertype),
    .tag_control (tag_control),
    .read_key    (read_key),
    .op          (front_op)
  );

  vaf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (front_op),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  vaf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .clearing   (clearing),
    .done       (done),
    .verdict    (verdict),
    .counted    (counted),
    .stat_key   (stat_key),
    .seen_count (seen_count),
    .pass_count (pass_count),
    .drop_count (drop_count)
  );

endmodule
`default_nettype wire
